// ----- design/lctf_pkg.sv -----
// Shared constants, operation codes, font table and request type for the LCD text frame buffer.
package lctf_pkg;

  localparam int COLUMNS_DEF   = 84;
  localparam int BANK_ROWS_DEF = 6;
  localparam int GLYPH_WIDTH   = 5;
  localparam int CELL_WIDTH    = GLYPH_WIDTH + 1;

  localparam logic [7:0] FIRST_CODE = 8'd32;
  localparam logic [7:0] LAST_CODE  = 8'd124;
  localparam logic [7:0] NUL_CODE   = 8'd0;

  localparam logic [2:0] OP_WRITE_CURSOR = 3'd0;
  localparam logic [2:0] OP_WRITE_AT     = 3'd1;
  localparam logic [2:0] OP_SET_POS      = 3'd2;
  localparam logic [2:0] OP_CLEAR        = 3'd3;
  localparam logic [2:0] OP_READ         = 3'd4;

  // Request to the position unit, launched when a word is accepted.
  typedef struct packed {
    logic       start;
    logic       set_pos;
    logic [8:0] position;
    logic [7:0] column;
    logic [7:0] row;
  } lctf_calc_req_t;

  // Five glyph columns per code, leftmost column in the top byte.
  localparam logic [39:0] GLYPH_ROM [93] = '{
    40'h0000000000, 40'h00002f0000, 40'h0007000700, 40'h147f147f14, 40'h242a7f2a12,
    40'hc4c8102646, 40'h3649552250, 40'h0005030000, 40'h001c224100, 40'h0041221c00,
    40'h14083e0814, 40'h08083e0808, 40'h0000503000, 40'h1010101010, 40'h0060600000,
    40'h2010080402, 40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
    40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503, 40'h3649494936,
    40'h064949291e, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324959513e, 40'h7e1111117e, 40'h7f49494936,
    40'h3e41414122, 40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
    40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
    40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e, 40'h7f09090906, 40'h3e4151215e,
    40'h7f09192946, 40'h4649494931, 40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f,
    40'h3f4038403f, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
    40'h552a552a55, 40'h0041417f00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7f48444438, 40'h3844444420, 40'h384444487f, 40'h3854545418,
    40'h087e090102, 40'h0c5252523e, 40'h7f08040478, 40'h00447d4000, 40'h2040443d00,
    40'h7f10284400, 40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
    40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420, 40'h043f444020,
    40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c, 40'h4428102844, 40'h0c5050503c,
    40'h4464544c44, 40'h086c6a1908, 40'h304e614e30
  };

  function automatic logic is_bad_code(input logic [7:0] code);
    return (code != NUL_CODE) && ((code < FIRST_CODE) || (code > LAST_CODE));
  endfunction

  // One byte of a character cell; the spacer column and bad codes give zero.
  function automatic logic [7:0] glyph_col(input logic [7:0] code, input logic [2:0] k);
    logic [6:0]  idx;
    logic [39:0] bits;
    logic [7:0]  col;
    idx  = 7'(code - FIRST_CODE);
    bits = '0;
    col  = '0;
    if ((code >= FIRST_CODE) && (code <= LAST_CODE)) begin
      bits = GLYPH_ROM[idx];
    end
    case (k)
      3'd0:    col = bits[39:32];
      3'd1:    col = bits[31:24];
      3'd2:    col = bits[23:16];
      3'd3:    col = bits[15:8];
      3'd4:    col = bits[7:0];
      default: col = '0;
    endcase
    return col;
  endfunction

endpackage

// ----- design/lcd_text_frame_buffer.sv -----
// Top level of the LCD text frame buffer: sequencer, cursor and output register.
// A write at a position, a set position and a read wait for the position unit, which folds a position past the frame
// back into it; a NUL write or an unused code gives its result without any memory access.
// One word is worked at a time; the next can be taken in the cycle after a result is loaded.
// After reset the frame memory is swept to zero before the first word is taken.
module lcd_text_frame_buffer
  import lctf_pkg::*;
#(
  parameter int COLUMNS   = COLUMNS_DEF,
  parameter int BANK_ROWS = BANK_ROWS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] operation_i,
  input  logic [7:0] char_code_i,
  input  logic [8:0] position_i,
  input  logic [7:0] column_i,
  input  logic [7:0] row_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o,
  output logic [8:0] cursor_now_o,
  output logic       bad_char_o
);

  localparam int FrameSize = COLUMNS * BANK_ROWS;
  localparam int AW        = $clog2(FrameSize);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CALC   = 3'd2;
  localparam logic [2:0] S_WRITE  = 3'd3;
  localparam logic [2:0] S_RDWAIT = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]     state_q, state_d;
  logic [AW-1:0]  cursor_q, cursor_d;
  logic [AW-1:0]  addr_q, addr_d;
  logic [AW-1:0]  addr_next;
  logic [2:0]     k_q, k_d;
  logic           emit_q, emit_d;
  logic [2:0]     op_q, op_d;
  logic [7:0]     code_q, code_d;
  logic           bad_q, bad_d;
  logic [7:0]     rd_q, rd_d;
  logic           out_valid_q, out_valid_d;
  logic [7:0]     read_data_q, read_data_d;
  logic [8:0]     cursor_now_q, cursor_now_d;
  logic           bad_char_q, bad_char_d;

  lctf_calc_req_t calc_req;
  logic           calc_done;
  logic [AW-1:0]  calc_result;

  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [7:0]     mem_wdata, mem_rdata;
  logic           accept, out_free;

  lctf_pos_unit #(
    .COLUMNS  (COLUMNS),
    .BANK_ROWS(BANK_ROWS),
    .AW       (AW)
  ) u_pos_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (calc_req),
    .done_o  (calc_done),
    .result_o(calc_result)
  );

  lctf_frame_mem #(
    .DEPTH(FrameSize),
    .AW   (AW)
  ) u_frame_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  lctf_addr_step #(
    .FRAME_SIZE(FrameSize),
    .AW        (AW)
  ) u_addr_step (
    .addr_i(addr_q),
    .next_o(addr_next)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    calc_req.start    = 1'b0;
    calc_req.set_pos  = (operation_i == OP_SET_POS);
    calc_req.position = position_i;
    calc_req.column   = column_i;
    calc_req.row      = row_i;
    if (accept) begin
      unique case (operation_i)
        OP_WRITE_AT:  calc_req.start = (char_code_i != NUL_CODE);
        OP_SET_POS:   calc_req.start = 1'b1;
        OP_READ:      calc_req.start = 1'b1;
        default:      calc_req.start = 1'b0;
      endcase
    end
  end

  // Accesses never overlap: the sequencer issues at most one memory access per cycle, for one word at a time.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = calc_result;
    if (state_q == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_q == S_WRITE) begin
      mem_we    = 1'b1;
      mem_wdata = glyph_col(code_q, k_q);
    end else if ((state_q == S_CALC) && calc_done && (op_q == OP_READ)) begin
      mem_re = 1'b1;
    end
  end

  always_comb begin
    state_d      = state_q;
    cursor_d     = cursor_q;
    addr_d       = addr_q;
    k_d          = k_q;
    emit_d       = emit_q;
    op_d         = op_q;
    code_d       = code_q;
    bad_d        = bad_q;
    rd_d         = rd_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    read_data_d  = read_data_q;
    cursor_now_d = cursor_now_q;
    bad_char_d   = bad_char_q;

    unique case (state_q)
      S_CLEAR: begin
        addr_d = addr_next;
        if (addr_q == AW'(FrameSize - 1)) begin
          state_d = emit_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_d   = operation_i;
          code_d = char_code_i;
          rd_d   = '0;
          bad_d  = 1'b0;
          k_d    = '0;
          unique case (operation_i) inside
            OP_WRITE_CURSOR: begin
              bad_d   = is_bad_code(char_code_i);
              addr_d  = cursor_q;
              state_d = (char_code_i == NUL_CODE) ? S_DONE : S_WRITE;
            end
            OP_WRITE_AT: begin
              bad_d   = is_bad_code(char_code_i);
              state_d = (char_code_i == NUL_CODE) ? S_DONE : S_CALC;
            end
            OP_SET_POS, OP_READ: begin
              state_d = S_CALC;
            end
            OP_CLEAR: begin
              cursor_d = '0;
              addr_d   = '0;
              emit_d   = 1'b1;
              state_d  = S_CLEAR;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_CALC: begin
        if (calc_done) begin
          unique case (op_q)
            OP_WRITE_AT: begin
              addr_d  = calc_result;
              state_d = S_WRITE;
            end
            OP_SET_POS: begin
              cursor_d = calc_result;
              state_d  = S_DONE;
            end
            default: begin
              state_d = S_RDWAIT;
            end
          endcase
        end
      end
      S_WRITE: begin
        addr_d = addr_next;
        k_d    = k_q + 3'd1;
        if (k_q == 3'(CELL_WIDTH - 1)) begin
          // The cursor lands on the byte after the spacer column.
          if (op_q == OP_WRITE_CURSOR) begin
            cursor_d = addr_next;
          end
          state_d = S_DONE;
        end
      end
      S_RDWAIT: begin
        rd_d    = mem_rdata;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          read_data_d  = rd_q;
          cursor_now_d = 9'(cursor_q);
          bad_char_d   = bad_q;
          emit_d       = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cursor_q    <= '0;
      addr_q      <= '0;
      emit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      addr_q      <= addr_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q          <= k_d;
    op_q         <= op_d;
    code_q       <= code_d;
    bad_q        <= bad_d;
    rd_q         <= rd_d;
    read_data_q  <= read_data_d;
    cursor_now_q <= cursor_now_d;
    bad_char_q   <= bad_char_d;
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = read_data_q;
  assign cursor_now_o = cursor_now_q;
  assign bad_char_o   = bad_char_q;

endmodule

// ----- design/lctf_frame_mem.sv -----
// Byte-wide frame memory with one write port and one registered read port.
module lctf_frame_mem
  import lctf_pkg::*;
#(
  parameter int DEPTH = COLUMNS_DEF * BANK_ROWS_DEF,
  parameter int AW    = $clog2(COLUMNS_DEF * BANK_ROWS_DEF)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- design/lctf_pos_unit.sv -----
// Iterative position unit: folds a byte address into the frame or resolves a column/row pair.
module lctf_pos_unit
  import lctf_pkg::*;
#(
  parameter int COLUMNS   = COLUMNS_DEF,
  parameter int BANK_ROWS = BANK_ROWS_DEF,
  parameter int AW        = $clog2(COLUMNS_DEF * BANK_ROWS_DEF)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lctf_calc_req_t req_i,
  output logic           done_o,
  output logic [AW-1:0]  result_o
);

  localparam int FrameSize = COLUMNS * BANK_ROWS;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic          set_pos_q, set_pos_d;
  logic [8:0]    x_q, x_d;
  logic [8:0]    y_q, y_d;
  logic [AW-1:0] result_q, result_d;
  logic          x_ge_col, y_ge_row, x_ge_frame, finished;
  logic [17:0]   linear;

  // Column overflow carries into the row while the row folds down, one step each per cycle.
  always_comb begin
    x_ge_col   = x_q >= 9'(COLUMNS);
    y_ge_row   = y_q >= 9'(BANK_ROWS);
    x_ge_frame = int'(x_q) >= FrameSize;
    finished   = set_pos_q ? (!x_ge_col && !y_ge_row) : !x_ge_frame;
    linear     = 18'(y_q) * 18'(COLUMNS) + 18'(x_q);

    busy_d    = busy_q;
    done_d    = 1'b0;
    set_pos_d = set_pos_q;
    x_d       = x_q;
    y_d       = y_q;
    result_d  = result_q;

    if (req_i.start) begin
      busy_d    = 1'b1;
      set_pos_d = req_i.set_pos;
      x_d       = req_i.set_pos ? {1'b0, req_i.column} : req_i.position;
      y_d       = req_i.set_pos ? {1'b0, req_i.row} : '0;
    end else if (busy_q) begin
      if (finished) begin
        busy_d   = 1'b0;
        done_d   = 1'b1;
        result_d = set_pos_q ? AW'(linear) : AW'(x_q);
      end else if (set_pos_q) begin
        x_d = x_ge_col ? x_q - 9'(COLUMNS) : x_q;
        y_d = y_q + {8'd0, x_ge_col} - (y_ge_row ? 9'(BANK_ROWS) : 9'd0);
      end else begin
        x_d = x_q - 9'(FrameSize);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    set_pos_q <= set_pos_d;
    x_q       <= x_d;
    y_q       <= y_d;
    result_q  <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ----- design/lctf_frame_mem_wrap_placeholder_removed.sv -----
// Write address stepper for cell writes and the clear sweep, wrapping at the end of the frame.
module lctf_addr_step
  import lctf_pkg::*;
#(
  parameter int FRAME_SIZE = COLUMNS_DEF * BANK_ROWS_DEF,
  parameter int AW         = $clog2(COLUMNS_DEF * BANK_ROWS_DEF)
) (
  input  logic [AW-1:0] addr_i,
  output logic [AW-1:0] next_o
);

  assign next_o = (addr_i == AW'(FRAME_SIZE - 1)) ? '0 : addr_i + AW'(1);

endmodule
